// ----- rtl/core/rfmci_pkg.sv -----
// ----------------------------------------------------------------------------
// rfmci_pkg
// Shared types and codes of the ring FIFO with multi-copy insert.
// ----------------------------------------------------------------------------
package rfmci_pkg;

  // Field widths fixed by the stream format
  localparam int DATA_W   = 32;
  localparam int COPY_W   = 4;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 4;

  // Packed stream widths (tdata filled up to whole bytes)
  localparam int S_TDATA_W = 40;   // phit_data, copy_count, pad
  localparam int S_TUSER_W = 1;    // cmd
  localparam int M_TDATA_W = 40;   // out_data, fill_count, free_count
  localparam int M_TUSER_W = 2;    // status

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_POP
  } state_t;

endpackage

// ----- rtl/core/ring_fifo_multi_copy_insert_unit.sv -----
// ----------------------------------------------------------------------------
// ring_fifo_multi_copy_insert_unit
// Circular FIFO that keeps one slot empty; an insert writes several copies
// of one word, a remove returns the head word. One result per request.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                    | tuser
//  --------+-----+---------------------------------------+---------
//  s_*     | in  | phit_data[31:0] copy_count[35:32] pad | cmd
//  m_*     | out | out_data[31:0] fill[35:32] free[39:36]| status
//
//  An insert writes its copies one per cycle through the single write port
//  of the slot memory, the first on acceptance and the rest in ST_COPY.
//  A remove reads the head word through the registered read port of the memory
//  and returns it from ST_POP; a remove rejected on an empty ring reads nothing.
//  Reset (rst, synchronous) clears head, tail and fill; the slot memory has
//  no reset and needs no clearing pass.
//  A new request is taken while idle and the result register is empty or drains.
//
module ring_fifo_multi_copy_insert_unit #(
  parameter int QUEUE_SLOTS = 16,
  parameter int WORD_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // phit_data [31:0], copy_count [35:32], zero pad [39:36]
  input  logic [rfmci_pkg::S_TDATA_W-1:0] s_tdata,
  // cmd [0]
  input  logic [rfmci_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_data [31:0], fill_count [35:32], free_count [39:36]
  output logic [rfmci_pkg::M_TDATA_W-1:0] m_tdata,
  // status [1:0]
  output logic [rfmci_pkg::M_TUSER_W-1:0] m_tuser
);
  import rfmci_pkg::*;

  localparam int IDX_W = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int CNT_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int MEM_W = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SLOTS - 1);
  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(QUEUE_SLOTS - 1);

  // Request fields
  logic               in_cmd;
  logic [MEM_W-1:0]   in_word;
  logic [COPY_W-1:0]  in_copies;

  assign in_cmd    = s_tuser[0];
  assign in_word   = s_tdata[MEM_W-1:0];
  assign in_copies = s_tdata[DATA_W +: COPY_W];

  // Registers
  state_t             state, state_next;
  logic [IDX_W-1:0]   head, head_next;
  logic [IDX_W-1:0]   tail, tail_next;
  logic [IDX_W-1:0]   fill, fill_next;
  logic [COPY_W-1:0]  copies_left, copies_left_next;
  logic [MEM_W-1:0]   word_q, word_next;
  logic [MEM_W-1:0]   rd_data;

  // Control strobes
  logic               s_acc;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [MEM_W-1:0]   wr_data;
  logic               mem_re;
  logic [IDX_W-1:0]   rd_addr;
  logic               res_load;
  logic [STAT_W-1:0]  res_status;
  logic [MEM_W-1:0]   res_data;

  // Derived values
  logic [IDX_W-1:0]   head_adv;
  logic [IDX_W-1:0]   tail_adv;
  logic [CNT_W-1:0]   space;
  logic               too_many;
  logic [CNT_W-1:0]   res_fill_ext;
  logic [CNT_W-1:0]   res_free_ext;

  logic [MEM_W-1:0]   mem [QUEUE_SLOTS];

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign s_acc    = s_tvalid && s_tready;

  // Wrap the ring pointers
  assign head_adv = (head == LAST_IDX) ? '0 : head + IDX_W'(1);
  assign tail_adv = (tail == LAST_IDX) ? '0 : tail + IDX_W'(1);

  // Free space against the requested copy count
  assign space    = CAPACITY - CNT_W'(fill);
  assign too_many = CNT_W'(in_copies) > space;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (in_cmd == CMD_REMOVE) begin
            if (fill != '0) state_next = ST_POP;
          end else if (!too_many && (in_copies > COPY_W'(1))) begin
            state_next = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        if (copies_left == COPY_W'(1)) state_next = ST_IDLE;
      end
      ST_POP:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls and register updates
  always_comb begin
    head_next        = head;
    tail_next        = tail;
    fill_next        = fill;
    copies_left_next = copies_left;
    word_next        = word_q;
    mem_we           = 1'b0;
    wr_addr          = tail_adv;
    wr_data          = word_q;
    mem_re           = 1'b0;
    rd_addr          = head_adv;
    res_load         = 1'b0;
    res_status       = STAT_OK;
    res_data         = '0;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (in_cmd == CMD_REMOVE) begin
            if (fill == '0) begin
              res_load   = 1'b1;
              res_status = STAT_UNDERFLOW;
            end else begin
              mem_re    = 1'b1;
              head_next = head_adv;
              fill_next = fill - IDX_W'(1);
            end
          end else if (too_many) begin
            res_load   = 1'b1;
            res_status = STAT_OVERFLOW;
          end else if (in_copies == '0) begin
            res_load = 1'b1;
          end else begin
            // write the first copy now, the rest one per cycle
            mem_we           = 1'b1;
            wr_data          = in_word;
            tail_next        = tail_adv;
            fill_next        = fill + IDX_W'(1);
            word_next        = in_word;
            copies_left_next = in_copies - COPY_W'(1);
            res_load         = (in_copies == COPY_W'(1));
          end
        end
      end
      ST_COPY: begin
        mem_we           = 1'b1;
        tail_next        = tail_adv;
        fill_next        = fill + IDX_W'(1);
        copies_left_next = copies_left - COPY_W'(1);
        res_load         = (copies_left == COPY_W'(1));
      end
      ST_POP: begin
        res_load = 1'b1;
        res_data = rd_data;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Counts after the request
  assign res_fill_ext = CNT_W'(fill_next);
  assign res_free_ext = CAPACITY - res_fill_ext;

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head        <= '0;
      tail        <= '0;
      fill        <= '0;
      copies_left <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      tail        <= tail_next;
      fill        <= fill_next;
      copies_left <= copies_left_next;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Capture the result and the word being copied
  always_ff @(posedge clk) begin
    word_q <= word_next;
    if (res_load) begin
      m_tdata <= {res_free_ext[COUNT_W-1:0], res_fill_ext[COUNT_W-1:0],
                  DATA_W'(res_data)};
      m_tuser <= res_status;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= mem[rd_addr];
  end

  // Pointer distance check
  logic [IDX_W:0] ptr_dist;
  assign ptr_dist = (tail >= head) ? ({1'b0, tail} - {1'b0, head})
                                   : ({1'b0, tail} + (IDX_W + 1)'(QUEUE_SLOTS)
                                      - {1'b0, head});

  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(fill) <= CAPACITY)
    else $error("fill exceeds capacity");

  a_fill_ptrs: assert property (@(posedge clk) disable iff (rst)
    ptr_dist == {1'b0, fill})
    else $error("fill does not match pointer distance");

  a_pop_from_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> $past(s_acc) && $past(in_cmd == CMD_REMOVE))
    else $error("pop state without accepted remove");

  a_result_after_pop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |=> m_tvalid && (m_tuser == STAT_OK))
    else $error("pop did not deliver a result");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready && !m_tvalid)
    else $error("request taken while busy");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks ring_fifo_multi_copy_insert_unit against a cycle-free predictor of
// the one-empty-slot ring: multi-copy inserts, removes, overflow and
// underflow rejects. Requests go in with random gaps, results come out under
// random back-pressure, and every result is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rfmci_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [DATA_W-1:0]  word;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] fill;
    logic [COUNT_W-1:0] free;
  } fifo_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // phit_data [31:0], copy_count [35:32], zero pad [39:36]
  logic [S_TDATA_W-1:0] s_tdata = '0;
  // cmd [0]
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // out_data [31:0], fill_count [35:32], free_count [39:36]
  logic [M_TDATA_W-1:0] m_tdata;
  // status [1:0]
  logic [M_TUSER_W-1:0] m_tuser;

  // Predictor state: slot words and ring pointers
  logic [DATA_W-1:0]  ring_words [SLOTS];
  logic [COUNT_W-1:0] head_ptr = '0;
  logic [COUNT_W-1:0] tail_ptr = '0;

  fifo_result_t pending_results[$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           src_idle_en = 1'b1;
  bit           snk_idle_en = 1'b1;
  int           stall_left  = 0;

  ring_fifo_multi_copy_insert_unit #(
    .QUEUE_SLOTS(SLOTS),
    .WORD_BITS  (DATA_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** ring_fifo_multi_copy_insert_unit: FAILED **");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [COUNT_W-1:0] ring_fill();
    return tail_ptr - head_ptr;
  endfunction

  // Apply one request to the predicted ring and return its result
  function automatic fifo_result_t fifo_apply_request(input logic cmd,
                                                      input logic [DATA_W-1:0] word,
                                                      input logic [COPY_W-1:0] copies);
    fifo_result_t res;
    logic [COUNT_W-1:0] space;
    res        = '0;
    res.status = STAT_OK;
    space      = 4'd15 - ring_fill();
    if (cmd == CMD_INSERT) begin
      if (copies > space) begin
        res.status = STAT_OVERFLOW;
      end else begin
        for (int k = 0; k < copies; k++) begin
          tail_ptr             = tail_ptr + COUNT_W'(1);
          ring_words[tail_ptr] = word;
        end
      end
    end else begin
      if (ring_fill() == 0) begin
        res.status = STAT_UNDERFLOW;
      end else begin
        head_ptr = head_ptr + COUNT_W'(1);
        res.word = ring_words[head_ptr];
      end
    end
    res.fill = ring_fill();
    res.free = 4'd15 - res.fill;
    return res;
  endfunction

  // Offer one request, hold it until taken, then record its expected result
  task automatic send_request(input logic cmd, input logic [DATA_W-1:0] word,
                              input logic [COPY_W-1:0] copies);
    int gap;
    gap = src_idle_en ? idle_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, copies, word};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(fifo_apply_request(cmd, word, copies));
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Drive result back-pressure
  always @(posedge clk) begin
    if (stall_left == 0) begin
      m_tready <= 1'b1;
      if (snk_idle_en && $urandom_range(0, 3) == 0) stall_left = idle_length();
    end else begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end
  end

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    fifo_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: tdata 0x%0h tuser 0x%0h",
               m_tdata, m_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_data",   want.word,             m_tdata[31:0]);
        check_field("status",     DATA_W'(want.status),  DATA_W'(m_tuser));
        check_field("fill_count", DATA_W'(want.fill),    DATA_W'(m_tdata[35:32]));
        check_field("free_count", DATA_W'(want.free),    DATA_W'(m_tdata[39:36]));
      end
    end
  end

  // Remove from empty, zero copies on an empty ring, data extremes
  task automatic test_empty_and_zero_copies();
    send_request(CMD_REMOVE, 32'hFFFF_FFFF, 4'hF);
    send_request(CMD_INSERT, 32'h1234_5678, 4'd0);
    send_request(CMD_REMOVE, 32'h0, 4'd0);
    send_request(CMD_INSERT, 32'h0000_0000, 4'd1);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 4'd1);
    send_request(CMD_REMOVE, 32'h0, 4'd0);
    send_request(CMD_REMOVE, 32'h0, 4'd0);
    send_request(CMD_REMOVE, 32'hA5A5_A5A5, 4'd7);
  endtask

  // Fill to capacity in one insert, then push against the full ring
  task automatic test_fill_and_overflow();
    send_request(CMD_INSERT, 32'hA5A5_A5A5, 4'd15);
    send_request(CMD_INSERT, 32'h5A5A_5A5A, 4'd1);
    send_request(CMD_INSERT, 32'h5A5A_5A5A, 4'd15);
    send_request(CMD_INSERT, 32'hDEAD_BEEF, 4'd0);
    send_request(CMD_REMOVE, 32'h0, 4'd0);
    send_request(CMD_INSERT, 32'h0F0F_0F0F, 4'd2);
    send_request(CMD_INSERT, 32'hF0F0_F0F0, 4'd1);
    send_request(CMD_REMOVE, 32'h0, 4'd0);
    send_request(CMD_INSERT, 32'h8000_0001, 4'd1);
  endtask

  // Random traffic in bursts that lean toward filling, draining or balance
  task automatic test_random_traffic(input int n_items);
    int bias;
    int burst_left;
    int r;
    int space;
    logic [DATA_W-1:0] word;
    logic [COPY_W-1:0] copies;
    bias       = 2;
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        bias       = $urandom_range(0, 2);
        burst_left = $urandom_range(20, 60);
      end
      burst_left--;
      word = $urandom;
      r    = $urandom_range(0, 99);
      if (r < 3) word = '0;
      else if (r < 6) word = '1;
      r = $urandom_range(0, 99);
      if ((bias == 0 && r < 70) || (bias == 1 && r < 25) || (bias == 2 && r < 50)) begin
        space = 15 - int'(ring_fill());
        r     = $urandom_range(0, 99);
        if (r < 10) copies = COPY_W'($urandom_range(0, 15));
        else if (r < 20) copies = COPY_W'(space);
        else if (r < 25) copies = (space < 15) ? COPY_W'(space + 1) : COPY_W'(15);
        else copies = COPY_W'($urandom_range(0, (space < 4) ? space : 4));
        send_request(CMD_INSERT, word, copies);
      end else begin
        // Ignored fields carry random content
        send_request(CMD_REMOVE, word, COPY_W'($urandom_range(0, 15)));
      end
    end
  endtask

  // Stop sending until every outstanding result has come back
  task automatic test_drain_pause();
    test_random_traffic(25);
    wait_results_drained();
    test_random_traffic(25);
  endtask

  // Full-rate stretch on both sides
  task automatic test_back_to_back(input int n_items);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_random_traffic(n_items);
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_zero_copies();
    test_fill_and_overflow();
    test_random_traffic(600);
    test_drain_pause();
    test_back_to_back(300);
    test_random_traffic(500);
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** ring_fifo_multi_copy_insert_unit: PASSED **");
    end else begin
      $display("** ring_fifo_multi_copy_insert_unit: FAILED **");
    end
    $finish;
  end

endmodule
